FILE: rtl/core/caseless_key_value_probe_table_macros.svh
// Assertion macros used by the probe table checker.
`ifndef CASELESS_KEY_VALUE_PROBE_TABLE_MACROS_SVH
`define CASELESS_KEY_VALUE_PROBE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKVP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CKVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ckvp_pkg.sv
// Types, codes and constants of the caseless key/value probe table.
package ckvp_pkg;

    // Bucket count; the slot output and the table size register are sized for it.
    localparam int          TABLE_DEPTH  = 128;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    // The FNV prime is 2^40 + 0x1B3; only the low part needs a multiplier.
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int          FNV_PRIME_SH = 40;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_MAX_VLEN   = 1'b1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOLD,
        S_CHECK,
        S_DIV,
        S_HEAD,
        S_PROBE,
        S_CMP_RD,
        S_CMP_CHK,
        S_COPY,
        S_NEXT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    fold;
        logic    div_start;
        logic    div_step;
        logic    advance;
        logic    idx_clr;
        logic    idx_inc;
        logic    ins_write;
        logic    copy_write;
        logic    set_res;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic is_lookup;
        logic too_long;
        logic overlong;
        logic div_last;
        logic used;
        logic len_eq;
        logic byte_eq;
        logic idx_last;
        logic probe_last;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'd32;
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/ckvp_ctrl.sv
// Sequencer for hashing, slot division, probing, compare, copy and result.
module ckvp_ctrl
    import ckvp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = i_stat.last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.too_long || (i_stat.is_lookup && i_stat.overlong)) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: n_state = S_PROBE;
            S_PROBE: begin
                if (!i_stat.used) begin
                    n_state = i_stat.is_lookup ? S_RESULT : S_COPY;
                end else if (i_stat.len_eq) begin
                    n_state = S_CMP_RD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_CMP_RD: n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (!i_stat.byte_eq) begin
                    n_state = S_NEXT;
                end else if (i_stat.idx_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_COPY: begin
                if (i_stat.idx_last) begin
                    n_state = S_RESULT;
                end
            end
            S_NEXT: n_state = i_stat.probe_last ? S_RESULT : S_HEAD;
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.accept = i_in_valid;
            S_FOLD: o_cmd.fold = 1'b1;
            S_CHECK: begin
                if (i_stat.too_long) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_TOO_LONG;
                end else if (i_stat.is_lookup && i_stat.overlong) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NOT_FOUND;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_PROBE: begin
                if (!i_stat.used) begin
                    if (i_stat.is_lookup) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_NOT_FOUND;
                    end else begin
                        o_cmd.ins_write = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                    end
                end else begin
                    o_cmd.idx_clr = 1'b1;
                end
            end
            S_CMP_CHK: begin
                if (i_stat.byte_eq && i_stat.idx_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = i_stat.is_lookup ? ST_FOUND : ST_DUPLICATE;
                end else if (i_stat.byte_eq) begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_COPY: begin
                o_cmd.copy_write = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_INSERTED;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_NEXT: begin
                if (i_stat.probe_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = i_stat.is_lookup ? ST_NOT_FOUND : ST_FULL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_RESULT: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/ckvp_dp.sv
// Hash, divider, bucket stores, key compare and result register.
module ckvp_dp
    import ckvp_pkg::*;
#(
    parameter int KEY_BYTES   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_action,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    input  logic [31:0] i_value_handle,
    input  logic [15:0] i_value_length,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [6:0]  o_slot_index
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int KW = $clog2(KEY_BYTES);
    localparam int NW = $clog2(KEY_BYTES + 1);
    localparam int CW = (SW + 1 > 9) ? SW + 1 : 9;
    localparam int KD = TABLE_DEPTH * (2 ** KW);

    logic [7:0]    r_table_size;
    logic [15:0]   r_max_vlen;
    logic [63:0]   r_hash;
    logic [63:0]   r_prod;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_action;
    logic [31:0]   r_handle;
    logic [15:0]   r_vlen;
    logic [NW-1:0] r_count;
    logic [7:0]    r_keybuf [KEY_BYTES];
    logic [5:0]    r_bit;
    logic [7:0]    r_rem;
    logic [7:0]    r_size;
    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_n;
    logic [KW-1:0] r_idx;
    logic          r_used [TABLE_DEPTH];
    logic [NW-1:0] r_len_mem [TABLE_DEPTH];
    logic [31:0]   r_val_mem [TABLE_DEPTH];
    logic [7:0]    r_key_mem [KD];
    logic [NW-1:0] r_len_q;
    logic [31:0]   r_val_q;
    logic [7:0]    r_kb_q;
    t_status       r_res;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [31:0]   r_value;
    logic [6:0]    r_slot_out;

    logic          overlong;
    logic [8:0]    rem_sh;
    logic [8:0]    rem_nx;
    logic [7:0]    size_eff;
    logic          out_free;
    logic [SW+KW-1:0] key_addr;

    assign overlong = (r_count == NW'(KEY_BYTES));
    assign rem_sh   = {r_rem, r_hash[r_bit]};
    assign rem_nx   = (rem_sh >= {1'b0, r_size}) ? rem_sh - {1'b0, r_size} : rem_sh;
    assign out_free = !r_out_valid || !i_out_stall;
    assign key_addr = {r_slot, r_idx};

    always_comb begin
        if (r_table_size == 8'd0) begin
            size_eff = 8'd1;
        end else if (int'(r_table_size) > TABLE_DEPTH) begin
            size_eff = 8'(TABLE_DEPTH);
        end else begin
            size_eff = r_table_size;
        end
    end

    always_comb begin
        o_stat.last       = r_last;
        o_stat.is_lookup  = (r_action == ACT_LOOKUP);
        o_stat.too_long   = (r_action == ACT_INSERT) && (overlong || (r_vlen >= r_max_vlen));
        o_stat.overlong   = overlong;
        o_stat.div_last   = (r_bit == 6'd0);
        o_stat.used       = r_used[r_slot];
        o_stat.len_eq     = (r_len_q == r_count);
        o_stat.byte_eq    = (r_kb_q == r_keybuf[r_idx]);
        o_stat.idx_last   = (NW'(r_idx) + NW'(1) == r_count);
        o_stat.probe_last = (r_n + CW'(1) == CW'(r_size));
        o_stat.out_free   = out_free;
    end

    // Configuration, hash, key count, bucket flags and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 8'd127;
            r_max_vlen   <= 16'd4096;
            r_hash       <= FNV_BASIS;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_used[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TABLE_SIZE) begin
                    r_table_size <= i_cfg_data[7:0];
                end else begin
                    r_max_vlen <= i_cfg_data;
                end
            end
            if (i_cmd.accept && !overlong) begin
                r_count <= r_count + NW'(1);
            end
            if (i_cmd.fold) begin
                r_hash <= (r_prod + {r_hash[63-FNV_PRIME_SH:0], {FNV_PRIME_SH{1'b0}}})
                          ^ {56'd0, r_byte};
            end
            if (i_cmd.ins_write) begin
                r_used[r_slot] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_hash      <= FNV_BASIS;
                r_count     <= '0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item fields, divider, probe position and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prod   <= r_hash * 64'(FNV_PRIME_LO);
            r_byte   <= fold_case(i_key_byte);
            r_last   <= i_key_last;
            r_action <= i_action;
            r_handle <= i_value_handle;
            r_vlen   <= i_value_length;
            if (!overlong) begin
                r_keybuf[r_count[KW-1:0]] <= fold_case(i_key_byte);
            end
        end
        if (i_cmd.div_start) begin
            r_rem  <= 8'd0;
            r_bit  <= 6'd63;
            r_size <= size_eff;
            r_n    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_nx[7:0];
            r_bit <= r_bit - 6'd1;
            if (r_bit == 6'd0) begin
                r_slot <= SW'(rem_nx);
            end
        end
        if (i_cmd.advance) begin
            r_n <= r_n + CW'(1);
            if (CW'(r_slot) + CW'(1) == CW'(r_size)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + SW'(1);
            end
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + KW'(1);
        end
        if (i_cmd.set_res) begin
            r_res <= i_cmd.res_code;
        end
        if (i_cmd.out_load) begin
            r_status   <= r_res;
            r_value    <= (r_res == ST_FOUND) ? r_val_q : 32'd0;
            r_slot_out <= (r_res == ST_FOUND || r_res == ST_INSERTED) ? 7'(r_slot) : 7'd0;
        end
    end

    // Bucket length and value stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            r_len_mem[r_slot] <= r_count;
            r_val_mem[r_slot] <= r_handle;
        end
        r_len_q <= r_len_mem[r_slot];
        r_val_q <= r_val_mem[r_slot];
    end

    // Bucket key byte store, one row of key bytes per bucket.
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_write) begin
            r_key_mem[key_addr] <= r_keybuf[r_idx];
        end
        r_kb_q <= r_key_mem[key_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_value_out  = r_value;
    assign o_slot_index = r_slot_out;

endmodule

FILE: rtl/core/caseless_key_value_probe_table.sv
// Caseless key/value probe table: FNV-1 hashed keys with linear probing.
// A key byte that is not the last is taken and folded into the hash; the next byte is taken right after.
// On the last byte the hash is folded, the key is checked, the slot is found by bit-serial modulo,
// then each bucket probed is read and its key bytes compared one by one, an insert copies the key
// byte by byte, and the result is loaded, which then waits for the output to be taken.
// Synchronous active-low reset clears control and all bucket flags and sets hash and
// configuration to their defaults at once; there is no clearing pass.
module caseless_key_value_probe_table
    import ckvp_pkg::*;
#(
    parameter int KEY_BYTES   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    input  logic [31:0] i_value_handle,
    input  logic [15:0] i_value_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [6:0]  o_slot_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ckvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ckvp_dp #(
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_key_byte     (i_key_byte),
        .i_key_last     (i_key_last),
        .i_value_handle (i_value_handle),
        .i_value_length (i_value_length),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_value_out    (o_value_out),
        .o_slot_index   (o_slot_index)
    );

endmodule

FILE: rtl/core/ckvp_checker.sv
// Port-level checker for the probe table and its bind to the top level.
`include "caseless_key_value_probe_table_macros.svh"

module ckvp_checker
    import ckvp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [31:0] o_value_out,
    input logic [6:0]  o_slot_index
);

    // A stalled result transaction keeps its payload.
    `CKVP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_value_out) && $stable(o_slot_index), "result changed while stalled")

    // Only a successful lookup carries a value handle.
    `CKVP_ASSERT_NOW(a_value_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_FOUND), o_value_out == 32'd0, "value handle on a result other than found")

    // Only an insert or a hit names a bucket.
    `CKVP_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_FOUND) && (o_status != ST_INSERTED), o_slot_index == 7'd0, "slot index on a miss or failure")

    // A key byte needs hashing and a check before any result can appear.
    `CKVP_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, !$rose(o_out_valid), "result right after a byte transaction")

endmodule

bind caseless_key_value_probe_table ckvp_checker u_ckvp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_value_out  (o_value_out),
    .o_slot_index (o_slot_index)
);

FILE: dv/caseless_key_value_probe_table_test.sv
// Self-checking testbench of the caseless key/value probe table.
`timescale 1ns / 1ps

module caseless_key_value_probe_table_test;
    import ckvp_pkg::*;

    localparam int DEPTH = 128;
    localparam int KEYMAX = 32;
    localparam logic [63:0] PRIME = 64'd1099511628211;
    localparam int STALL_LIMIT = 50000;

    typedef struct {
        logic        act;
        logic [7:0]  kb;
        logic        last;
        logic [31:0] handle;
        logic [15:0] vlen;
        logic        chk;   // typed-in expectation present
        t_status     st;
        logic [31:0] val;
        logic [6:0]  slot;
    } row_t;

    typedef struct {
        t_status     st;
        logic [31:0] val;
        logic [6:0]  slot;
    } answer_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_action = 1'b0;
    logic [7:0]  i_key_byte = '0;
    logic        i_key_last = 1'b0;
    logic [31:0] i_value_handle = '0;
    logic [15:0] i_value_length = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_stall, o_out_valid, o_cfg_ready;
    logic [2:0]  o_status;
    logic [31:0] o_value_out;
    logic [6:0]  o_slot_index;

    caseless_key_value_probe_table dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state.
    logic [7:0]  tsize;
    logic [15:0] vlimit;
    logic [63:0] hash;
    logic [7:0]  kbuf [KEYMAX];
    int          kcount;
    logic        used [DEPTH];
    logic [7:0]  bkey [DEPTH][KEYMAX];
    int          blen [DEPTH];
    logic [31:0] bval [DEPTH];

    answer_t answers_pending [$];
    int      errors = 0;
    int      quiet = 0;
    bit      in_done = 0;

    function automatic logic [7:0] lower(logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic bit same_key(int s);
        if (blen[s] != kcount) return 0;
        for (int i = 0; i < kcount; i++)
            if (bkey[s][i] != kbuf[i]) return 0;
        return 1;
    endfunction

    // Folds one byte; returns 1 with the answer when the byte ends a key.
    function automatic bit table_step(row_t r, output answer_t a);
        int size, s;
        bit over;
        logic [7:0] b;
        b = lower(r.kb);
        hash = (hash * PRIME) ^ {56'd0, b};
        if (kcount < KEYMAX) begin
            kbuf[kcount] = b;
            kcount++;
        end
        if (!r.last) return 0;
        size = (tsize == 0) ? 1 : (tsize > DEPTH ? DEPTH : tsize);
        over = kcount >= KEYMAX;
        s = int'(hash % 64'(size));
        a = '{ST_NOT_FOUND, 32'd0, 7'd0};
        if (r.act == ACT_INSERT) begin
            if (over || r.vlen >= vlimit) begin
                a.st = ST_TOO_LONG;
            end else begin
                a.st = ST_FULL;
                for (int n = 0; n < size; n++) begin
                    if (!used[s]) begin
                        used[s] = 1;
                        for (int i = 0; i < kcount; i++) bkey[s][i] = kbuf[i];
                        blen[s] = kcount;
                        bval[s] = r.handle;
                        a = '{ST_INSERTED, 32'd0, 7'(s)};
                        break;
                    end
                    if (same_key(s)) begin
                        a.st = ST_DUPLICATE;
                        break;
                    end
                    s = (s + 1 == size) ? 0 : s + 1;
                end
            end
        end else if (!over) begin
            for (int n = 0; n < size; n++) begin
                if (!used[s]) break;
                if (same_key(s)) begin
                    a = '{ST_FOUND, bval[s], 7'(s)};
                    break;
                end
                s = (s + 1 == size) ? 0 : s + 1;
            end
        end
        hash = FNV_BASIS;
        kcount = 0;
        return 1;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_TABLE_SIZE) tsize = data[7:0];
        else vlimit = data;
    endtask

    // Valid stays high from one transaction into the next when no wait is drawn.
    task automatic send_byte(row_t r);
        answer_t a;
        int w;
        w = $urandom_range(0, 4);
        if (w > 0) begin
            i_in_valid <= 1'b0;
            idle_cycles(w);
        end
        i_in_valid <= 1'b1;
        i_action <= r.act;
        i_key_byte <= r.kb;
        i_key_last <= r.last;
        i_value_handle <= r.handle;
        i_value_length <= r.vlen;
        do @(posedge i_clk); while (o_in_stall);
        if (table_step(r, a)) begin
            if (r.chk && (a.st != r.st || a.val != r.val || a.slot != r.slot)) begin
                $display("%0t predictor disagrees with table row: expected %0d/%h/%0d got %0d/%h/%0d",
                         $time, r.st, r.val, r.slot, a.st, a.val, a.slot);
                errors++;
            end
            answers_pending.push_back(a);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (answers_pending.size() != 0) @(posedge i_clk);
        idle_cycles(2 * KEYMAX * 4);
    endtask

    // Sends a whole key; bytes come from a small alphabet so keys repeat, or are random for a negative seed.
    task automatic send_key(logic act, int len, int seed, logic [31:0] h, logic [15:0] vl);
        row_t r;
        for (int i = 0; i < len; i++) begin
            r = '{st: ST_INSERTED, default: '0};
            r.act = act;
            r.kb = (seed < 0) ? 8'($urandom) : 8'("a" + ((seed * 7 + i * 3) % 5))
                   - (($urandom_range(0, 1) != 0) ? 8'd32 : 8'd0);
            r.last = (i == len - 1);
            r.handle = h;
            r.vlen = vl;
            send_byte(r);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        answer_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %0d/%h/%0d",
                         $time, o_status, o_value_out, o_slot_index);
                errors++;
            end else begin
                e = answers_pending.pop_front();
                if (o_status != e.st) begin
                    $display("%0t status: expected %0d actual %0d", $time, e.st, o_status);
                    errors++;
                end
                if (o_value_out != e.val) begin
                    $display("%0t value: expected %h actual %h", $time, e.val, o_value_out);
                    errors++;
                end
                if (o_slot_index != e.slot) begin
                    $display("%0t slot: expected %0d actual %0d", $time, e.slot, o_slot_index);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: a random wait before each transaction is taken.
    int hold = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) hold <= $urandom_range(0, 4);
        else if (hold > 0) hold <= hold - 1;
        i_out_stall <= (o_out_valid && !i_out_stall) ? ($urandom_range(0, 4) != 0) :
                       (hold > 1);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    row_t dir [$];

    function automatic row_t mk(logic act, logic [7:0] kb, logic last, logic [31:0] h,
                                logic [15:0] vl, logic chk, t_status st,
                                logic [31:0] v, logic [6:0] sl);
        return '{act, kb, last, h, vl, chk, st, v, sl};
    endfunction

    initial begin
        int len, kind;
        tsize = 8'd127;
        vlimit = 16'd4096;
        hash = FNV_BASIS;
        kcount = 0;
        for (int i = 0; i < DEPTH; i++) used[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at reset configuration.
        dir.push_back(mk(ACT_LOOKUP, 8'hFF, 1, 0, 0, 1, ST_NOT_FOUND, 0, 0));
        dir.push_back(mk(ACT_INSERT, 8'h00, 1, 32'hFFFFFFFF, 16'hFFFF, 1, ST_TOO_LONG, 0, 0));
        dir.push_back(mk(ACT_INSERT, "K", 0, 0, 0, 0, ST_INSERTED, 0, 0));
        dir.push_back(mk(ACT_INSERT, "Z", 1, 32'hFFFFFFFF, 16'd4095, 0, ST_INSERTED, 0, 0));
        dir.push_back(mk(ACT_INSERT, "k", 0, 0, 0, 0, ST_INSERTED, 0, 0));
        dir.push_back(mk(ACT_INSERT, "z", 1, 32'h1234, 16'd0, 0, ST_DUPLICATE, 0, 0));
        dir.push_back(mk(ACT_LOOKUP, "k", 0, 0, 0, 0, ST_FOUND, 0, 0));
        dir.push_back(mk(ACT_LOOKUP, "Z", 1, 0, 0, 0, ST_FOUND, 0, 0));
        dir.push_back(mk(ACT_INSERT, 8'h00, 1, 32'h0, 16'd4096, 1, ST_TOO_LONG, 0, 0));
        dir.push_back(mk(ACT_INSERT, 8'h00, 1, 32'h5A5A5A5A, 16'd1, 0, ST_INSERTED, 0, 0));
        dir.push_back(mk(ACT_LOOKUP, 8'h00, 1, 0, 0, 0, ST_FOUND, 0, 0));
        foreach (dir[i]) send_byte(dir[i]);
        // Overlong key on insert and lookup.
        send_key(ACT_INSERT, KEYMAX, -1, 32'h1, 16'd1);
        send_key(ACT_LOOKUP, KEYMAX + 3, -1, 32'h1, 16'd1);
        drain();

        // Table size one: full table, then size zero acts as one, then a length limit of zero.
        write_reg(REG_TABLE_SIZE, 16'd1);
        write_reg(REG_MAX_VLEN, 16'd1);
        send_key(ACT_INSERT, 2, 1, 32'h77, 16'd0);
        send_key(ACT_INSERT, 3, 2, 32'h78, 16'd0);
        send_key(ACT_LOOKUP, 3, 2, 0, 0);
        drain();
        write_reg(REG_TABLE_SIZE, 16'd0);
        send_key(ACT_LOOKUP, 2, 1, 0, 0);
        drain();
        write_reg(REG_MAX_VLEN, 16'd0);
        send_key(ACT_INSERT, 1, 3, 32'h9, 16'd0);
        drain();

        // Random phases through several settings, including the extremes.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_TABLE_SIZE, 16'd4); write_reg(REG_MAX_VLEN, 16'd100); end
                1: begin write_reg(REG_TABLE_SIZE, 16'd128); write_reg(REG_MAX_VLEN, 16'hFFFF); end
                2: begin write_reg(REG_TABLE_SIZE, 16'd255); write_reg(REG_MAX_VLEN, 16'd1); end
                3: write_reg(REG_TABLE_SIZE, 16'd7);
                4: begin write_reg(REG_TABLE_SIZE, 16'd2); write_reg(REG_MAX_VLEN, 16'd4096); end
                default: write_reg(REG_TABLE_SIZE, 16'($urandom_range(1, 128)));
            endcase
            for (int k = 0; k < 30; k++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0) len = $urandom_range(KEYMAX - 1, KEYMAX + 2);
                else len = $urandom_range(1, 6);
                send_key(logic'($urandom_range(0, 1)), len,
                         (kind == 1) ? -1 : $urandom_range(0, 12),
                         $urandom, (kind < 3) ? 16'($urandom) : 16'($urandom_range(0, 3)));
            end
            drain();
        end
        in_done = 1;

        if (errors == 0 && answers_pending.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ckvp_pkg.sv
rtl/core/ckvp_ctrl.sv
rtl/core/ckvp_dp.sv
rtl/core/caseless_key_value_probe_table.sv
rtl/core/ckvp_checker.sv
dv/caseless_key_value_probe_table_test.sv
